// ===== hdl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and codes of the best-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

	localparam int DIV_W   = 17;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_DIV,
		S_SCAN_RD,
		S_SCAN_EV,
		S_NB_L,
		S_NB_R,
		S_NB_C,
		S_WR,
		S_DONE
	} bfa_state_t;

	localparam logic [2:0] WS_LAST = 3'd5;

endpackage

`default_nettype wire

// ===== hdl/bfa_div.sv =====
// ----------------------------------------------------------------------------
// bfa_div
// Divide by the block size through a rounded-up reciprocal; dividend, quotient and remainder are registered in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_div
	import bfa_pkg::*;
#(
	parameter int BLOCK_BYTES = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [DIV_W-1:0]                  dividend,
	output logic                                   done,
	output logic [DIV_W-1:0]                       quot,
	output logic [$clog2(BLOCK_BYTES)+1-1:0]       rem
);

	// shift of DIV_W + ceil(log2 B) keeps the quotient exact for any dividend
	localparam int SH = DIV_W + $clog2(BLOCK_BYTES);
	localparam int MW = DIV_W + 2;
	localparam int PW = DIV_W + MW;
	localparam int RW = $clog2(BLOCK_BYTES) + 1;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

	logic [DIV_W-1:0] x_q;
	logic             run_q;
	logic [DIV_W-1:0] q_s1;
	logic             vld_s1;
	logic [RW-1:0]    r_s2;
	logic             vld_s2;
	logic [PW-1:0]    prod;
	logic [DIV_W-1:0] quot_c;
	logic [DIV_W-1:0] back;
	logic [DIV_W-1:0] r_full;

	assign prod   = {{MW{1'b0}}, x_q} * {{DIV_W{1'b0}}, RECIP};
	assign quot_c = DIV_W'(prod >> SH);
	assign back   = q_s1 * DIV_W'(BLOCK_BYTES);
	assign r_full = x_q - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			run_q  <= start;
			vld_s1 <= run_q;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
		end
		if (run_q) begin
			q_s1 <= quot_c;
		end
		if (vld_s1) begin
			r_s2 <= r_full[RW-1:0];
		end
	end

	assign done = vld_s2;
	assign quot = q_s1;
	assign rem  = r_s2;

endmodule

`default_nettype wire

// ===== hdl/bfa_tag_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_tag_ram
// Boundary-tag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_tag_ram #(
	parameter int AW = 10,
	parameter int TW = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [TW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [TW-1:0] rdata
);

	logic [TW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/best_fit_block_allocator.sv =====
// Flow of a word: divide by the block size, walk the runs of the tag table
// with one tag read per run, then, for an allocate that fits or a free that
// takes effect, write the tags; a word that fails the divide check skips the
// walk. One word at a time: the next is taken once the result is registered.
// After reset a clearing pass over all NUM_BLOCKS entries rebuilds the tag
// table; no word is accepted during it.
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit pool allocator over a boundary-tag table held in one RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_block_allocator
	import bfa_pkg::*;
#(
	parameter int NUM_BLOCKS  = 1024,
	parameter int BLOCK_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [15:0] size_bytes,
	input  wire logic [14:0] offset,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [14:0]      result_offset
);

	localparam int AW = $clog2(NUM_BLOCKS);
	localparam int CW = AW + 1;
	localparam int TW = CW + 1;
	localparam int RW = $clog2(BLOCK_BYTES) + 1;

	bfa_state_t state_q, state_d;

	logic             op_q, zero_q;
	logic [CW-1:0]    need_q, idx_q, i_q, best_q, blen_q, cnt_q;
	logic             found_q;
	logic [TW-1:0]    left_q, right_q;
	logic [2:0]       ws_q;
	logic [AW-1:0]    clr_q;
	logic [1:0]       res_st_d, status_q;
	logic [14:0]      roff_q;
	logic             out_valid_q;

	logic             div_start, div_done;
	logic [DIV_W-1:0] div_in, quot;
	logic [RW-1:0]    rem;

	logic             we;
	logic [AW-1:0]    waddr, raddr;
	logic [TW-1:0]    wdata, rdata;

	logic             accept;
	logic             t_neg, len_bad, upd, found_nx, lv, rv;
	logic [TW-1:0]    len;
	logic [31:0]      nxt_i, wa32, rem_len, total, start_a, end_a, boff;
	logic             div_bad;

	assign accept = in_valid && !in_stall;

	assign div_start = accept;
	assign div_in = (op == OP_ALLOC) ?
		(DIV_W'(size_bytes) + DIV_W'(BLOCK_BYTES - 1)) : DIV_W'(offset);

	bfa_div #(.BLOCK_BYTES(BLOCK_BYTES)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_in),
		.done(div_done), .quot(quot), .rem(rem)
	);

	bfa_tag_ram #(.AW(AW), .TW(TW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// run walk decode
	assign t_neg    = rdata[TW-1];
	assign len      = t_neg ? (TW'(0) - rdata) : rdata;
	assign len_bad  = (len == '0) || (32'(len) > 32'(NUM_BLOCKS) - 32'(i_q));
	assign nxt_i    = 32'(i_q) + 32'(len);
	assign upd      = !t_neg && (len[CW-1:0] >= need_q) && !len[TW-1] &&
		(!found_q || len[CW-1:0] < blen_q);
	assign found_nx = found_q || upd;

	assign div_bad = (op_q == OP_ALLOC) ?
		(zero_q || 32'(quot) > 32'(NUM_BLOCKS)) :
		(rem != '0 || 32'(quot) >= 32'(NUM_BLOCKS));

	// merge neighbours
	assign lv      = (idx_q != '0) && !left_q[TW-1] && (left_q != '0);
	assign rv      = (32'(idx_q) + 32'(cnt_q) < 32'(NUM_BLOCKS)) &&
		!right_q[TW-1] && (right_q != '0);
	assign rem_len = 32'(blen_q) - 32'(need_q);
	assign total   = 32'(cnt_q) + (lv ? 32'(left_q) : 32'd0) +
		(rv ? 32'(right_q) : 32'd0);
	assign start_a = 32'(idx_q) - (lv ? 32'(left_q) : 32'd0);
	assign end_a   = 32'(idx_q) + 32'(cnt_q) + (rv ? 32'(right_q) : 32'd0) - 32'd1;
	assign boff    = 32'(best_q) * 32'(BLOCK_BYTES);

	// next state
	always_comb begin
		state_d  = state_q;
		res_st_d = ST_DONE;
		case (state_q)
			S_CLR: begin
				if (clr_q == AW'(NUM_BLOCKS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					if (div_bad) begin
						state_d  = S_DONE;
						res_st_d = (op_q == OP_ALLOC) ? ST_NOFIT : ST_IGNORED;
					end else begin
						state_d = S_SCAN_RD;
					end
				end
			end
			S_SCAN_RD: state_d = S_SCAN_EV;
			S_SCAN_EV: begin
				if (op_q == OP_ALLOC) begin
					if (len_bad) begin
						state_d  = found_q ? S_WR : S_DONE;
						res_st_d = ST_NOFIT;
					end else if (nxt_i < 32'(NUM_BLOCKS)) begin
						state_d = S_SCAN_RD;
					end else begin
						state_d  = found_nx ? S_WR : S_DONE;
						res_st_d = ST_NOFIT;
					end
				end else begin
					res_st_d = ST_IGNORED;
					if (len_bad) begin
						state_d = S_DONE;
					end else if (i_q == idx_q) begin
						state_d = t_neg ? S_NB_L : S_DONE;
					end else if (nxt_i < 32'(NUM_BLOCKS) && nxt_i <= 32'(idx_q)) begin
						state_d = S_SCAN_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_NB_L: state_d = S_NB_R;
			S_NB_R: state_d = S_NB_C;
			S_NB_C: state_d = S_WR;
			S_WR: begin
				if (ws_q == WS_LAST) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	// RAM ports and handshake
	always_comb begin
		we       = 1'b0;
		wa32     = '0;
		wdata    = '0;
		raddr    = i_q[AW-1:0];
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_CLR: begin
				we    = 1'b1;
				wa32  = 32'(clr_q);
				wdata = (clr_q == '0 || clr_q == AW'(NUM_BLOCKS - 1)) ?
					TW'(NUM_BLOCKS) : '0;
			end
			S_NB_L: raddr = AW'(32'(idx_q) - 32'd1);
			S_NB_R: raddr = AW'(32'(idx_q) + 32'(cnt_q));
			S_WR: begin
				if (op_q == OP_ALLOC) begin
					case (ws_q)
						3'd0: begin
							we = 1'b1; wa32 = 32'(best_q);
							wdata = TW'(0) - TW'(need_q);
						end
						3'd1: begin
							we = 1'b1; wa32 = 32'(best_q) + 32'(need_q) - 32'd1;
							wdata = TW'(0) - TW'(need_q);
						end
						3'd2: begin
							we = (rem_len != '0); wa32 = 32'(best_q) + 32'(need_q);
							wdata = TW'(rem_len);
						end
						3'd3: begin
							we = (rem_len != '0); wa32 = 32'(best_q) + 32'(blen_q) - 32'd1;
							wdata = TW'(rem_len);
						end
						default: we = 1'b0;
					endcase
				end else begin
					case (ws_q)
						3'd0: begin
							we = 1'b1; wa32 = 32'(idx_q);
						end
						3'd1: begin
							we = 1'b1; wa32 = 32'(idx_q) + 32'(cnt_q) - 32'd1;
						end
						3'd2: begin
							we = lv; wa32 = 32'(idx_q) - 32'd1;
						end
						3'd3: begin
							we = rv; wa32 = 32'(idx_q) + 32'(cnt_q);
						end
						3'd4: begin
							we = 1'b1; wa32 = start_a; wdata = TW'(total);
						end
						3'd5: begin
							we = 1'b1; wa32 = end_a; wdata = TW'(total);
						end
						default: we = 1'b0;
					endcase
				end
			end
			default: we = 1'b0;
		endcase
	end

	assign waddr = wa32[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			ws_q        <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: clr_q <= clr_q + 1'b1;
				S_DIV: begin
					found_q <= 1'b0;
					ws_q    <= '0;
				end
				S_SCAN_EV: begin
					if (op_q == OP_ALLOC && !len_bad && upd) begin
						found_q <= 1'b1;
					end
				end
				S_WR: ws_q <= ws_q + 1'b1;
				S_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= op;
				zero_q <= (size_bytes == '0);
			end
			S_DIV: begin
				need_q <= quot[CW-1:0];
				idx_q  <= quot[CW-1:0];
				i_q    <= '0;
			end
			S_SCAN_EV: begin
				i_q   <= nxt_i[CW-1:0];
				cnt_q <= len[CW-1:0];
				if (op_q == OP_ALLOC && !len_bad && upd) begin
					best_q <= i_q;
					blen_q <= len[CW-1:0];
				end
			end
			S_NB_R: left_q  <= rdata;
			S_NB_C: right_q <= rdata;
			default: ;
		endcase
		if (state_q != S_DONE && state_d == S_DONE) begin
			if (state_q == S_WR) begin
				status_q <= ST_DONE;
				roff_q   <= (op_q == OP_ALLOC) ? boff[14:0] : 15'd0;
			end else begin
				status_q <= res_st_d;
				roff_q   <= '0;
			end
		end
		if (state_q == S_DONE && !out_valid_q) begin
			status        <= status_q;
			result_offset <= roff_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_locks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("word taken while busy");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_EV || state_q == S_SCAN_RD) |-> !we)
		else $error("tag write during run walk");

	a_fail_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DONE) |-> (result_offset == '0))
		else $error("failed word carries an offset");

	a_clear_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> in_stall)
		else $error("input open during clearing pass");
`endif

endmodule

`default_nettype wire
